### hw/rtl/nsf_pkg.sv
package nsf_pkg;

    localparam int unsigned MAX_SENTENCE_LEN = 85;
    localparam int unsigned HDR_LEN          = 7;
    localparam int unsigned COUNT_W          = 7;
    localparam int unsigned HDR_IDX_W        = $clog2(HDR_LEN);

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;

    localparam logic [15:0] STR_GP   = "GP";
    localparam logic [31:0] STR_PMTK = "PMTK";
    localparam logic [23:0] STR_RMC  = "RMC";
    localparam logic [23:0] STR_GGA  = "GGA";
    localparam logic [23:0] STR_GSA  = "GSA";
    localparam logic [23:0] STR_GSV  = "GSV";
    localparam logic [23:0] STR_011  = "011";
    localparam logic [23:0] STR_010  = "010";

    typedef enum logic [2:0] {
        KIND_OTHER   = 3'd0,
        KIND_RMC     = 3'd1,
        KIND_GGA     = 3'd2,
        KIND_GSA     = 3'd3,
        KIND_GSV     = 3'd4,
        KIND_PMTK011 = 3'd5,
        KIND_PMTK010 = 3'd6
    } kind_t;

    typedef logic [HDR_LEN-1:0][7:0] hdr_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                v = c - 8'h30;
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                v = c - 8'h37;
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                v = c - 8'h57;
            end
            return v[3:0];
        end
    endfunction

    function automatic kind_t classify(input hdr_t h);
        logic [15:0] pre2;
        logic [31:0] pre4;
        logic [23:0] gp_tail;
        logic [23:0] mtk_tail;
        kind_t       k;
        begin
            pre2     = {h[0], h[1]};
            pre4     = {h[0], h[1], h[2], h[3]};
            gp_tail  = {h[2], h[3], h[4]};
            mtk_tail = {h[4], h[5], h[6]};
            k        = KIND_OTHER;
            if (pre2 == STR_GP)
            begin
                if (gp_tail == STR_RMC)
                begin
                    k = KIND_RMC;
                end
                else if (gp_tail == STR_GGA)
                begin
                    k = KIND_GGA;
                end
                else if (gp_tail == STR_GSA)
                begin
                    k = KIND_GSA;
                end
                else if (gp_tail == STR_GSV)
                begin
                    k = KIND_GSV;
                end
            end
            else if (pre4 == STR_PMTK)
            begin
                if (mtk_tail == STR_011)
                begin
                    k = KIND_PMTK011;
                end
                else if (mtk_tail == STR_010)
                begin
                    k = KIND_PMTK010;
                end
            end
            return k;
        end
    endfunction

endpackage

### hw/rtl/nmea_sentence_framer_top.sv
// Timing: a byte is registered on acceptance and processed from the input register while the
// result register is not stalled; the result for the second checksum digit is registered when that digit is processed.
// Throughput: one byte per cycle, limited only by a stalled result register.
// Reset (rst_n low, asynchronous): framer returns to idle, checksum, count and header
// capture clear, input and result registers empty.
module nmea_sentence_framer_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] rx_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [2:0] sentence_kind,
    output logic       checksum_ok,
    output logic [7:0] received_checksum,
    output logic [7:0] computed_checksum,
    output logic [6:0] body_length
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BODY = 2'd1,
        PH_HEX1 = 2'd2,
        PH_HEX2 = 2'd3
    } phase_t;

    phase_t                               phase_reg, phase_next;
    logic [7:0]                           xor_reg, xor_next;
    logic [3:0]                           nibble_reg, nibble_next;
    logic [nsf_pkg::COUNT_W-1:0]          count_reg, count_next;
    nsf_pkg::hdr_t                        hdr_reg, hdr_next;

    logic                                 in_vld_reg, in_vld_next;
    logic [7:0]                           in_byte_reg;

    logic                                 res_vld_reg, res_vld_next;
    nsf_pkg::kind_t                       res_kind_reg;
    logic                                 res_ok_reg;
    logic [7:0]                           res_rx_reg;
    logic [7:0]                           res_xor_reg;
    logic [nsf_pkg::COUNT_W-1:0]          res_len_reg;

    logic                                 proc_stall;
    logic                                 proc_fire;
    logic                                 in_accept;
    logic                                 emit;
    logic [nsf_pkg::COUNT_W:0]            count_inc;
    logic [7:0]                           rx_sum;

    assign proc_stall = res_vld_reg && result_stall;
    assign proc_fire  = in_vld_reg && !proc_stall;
    assign byte_stall = in_vld_reg && proc_stall;
    assign in_accept  = byte_valid && !byte_stall;
    assign emit       = proc_fire && (phase_reg == PH_HEX2);
    assign count_inc  = {1'b0, count_reg} + 1'b1;
    assign rx_sum     = {nibble_reg, nsf_pkg::hex_value(in_byte_reg)};

    always_comb
    begin
        phase_next  = phase_reg;
        xor_next    = xor_reg;
        nibble_next = nibble_reg;
        count_next  = count_reg;
        hdr_next    = hdr_reg;
        if (proc_fire)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (in_byte_reg == nsf_pkg::CHAR_DOLLAR)
                    begin
                        count_next = '0;
                        xor_next   = 8'd0;
                        hdr_next   = '0;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (count_inc >= (nsf_pkg::COUNT_W+1)'(nsf_pkg::MAX_SENTENCE_LEN))
                    begin
                        count_next = '0;
                        phase_next = PH_IDLE;
                    end
                    else if (in_byte_reg == nsf_pkg::CHAR_STAR)
                    begin
                        phase_next = PH_HEX1;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ in_byte_reg;
                        if (count_reg < nsf_pkg::COUNT_W'(nsf_pkg::HDR_LEN))
                        begin
                            hdr_next[count_reg[nsf_pkg::HDR_IDX_W-1:0]] = in_byte_reg;
                        end
                        count_next = count_inc[nsf_pkg::COUNT_W-1:0];
                    end
                end
                PH_HEX1:
                begin
                    nibble_next = nsf_pkg::hex_value(in_byte_reg);
                    phase_next  = PH_HEX2;
                end
                PH_HEX2:
                begin
                    count_next = '0;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (proc_fire)
        begin
            in_vld_next = 1'b0;
        end
        res_vld_next = res_vld_reg;
        if (emit)
        begin
            res_vld_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            xor_reg     <= 8'd0;
            nibble_reg  <= 4'd0;
            count_reg   <= '0;
            hdr_reg     <= '0;
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            xor_reg     <= xor_next;
            nibble_reg  <= nibble_next;
            count_reg   <= count_next;
            hdr_reg     <= hdr_next;
            in_vld_reg  <= in_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= rx_byte;
        end
        if (emit)
        begin
            res_kind_reg <= nsf_pkg::classify(hdr_reg);
            res_ok_reg   <= (rx_sum == xor_reg);
            res_rx_reg   <= rx_sum;
            res_xor_reg  <= xor_reg;
            res_len_reg  <= count_reg;
        end
    end

    assign result_valid      = res_vld_reg;
    assign sentence_kind     = res_kind_reg;
    assign checksum_ok       = res_ok_reg;
    assign received_checksum = res_rx_reg;
    assign computed_checksum = res_xor_reg;
    assign body_length       = res_len_reg;

`ifndef SYNTHESIS
    a_rise_from_hex2: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_vld_reg) |-> $past(emit))
        else $error("result appeared without a second checksum digit");

    a_ok_matches: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg |-> (res_ok_reg == (res_rx_reg == res_xor_reg)))
        else $error("checksum_ok disagrees with checksums");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < nsf_pkg::COUNT_W'(nsf_pkg::MAX_SENTENCE_LEN))
        else $error("body count reached maximum length");

    a_idle_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE && phase_next != PH_IDLE) |-> (phase_next == PH_BODY))
        else $error("idle left for a phase other than body");
`endif

endmodule

### dv/nmea_sentence_framer_checker.sv
`timescale 1ns / 100ps

module nmea_sentence_framer_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       byte_stall,
    input  logic [7:0] rx_byte,
    input  logic       result_valid,
    input  logic       result_stall,
    input  logic [2:0] sentence_kind,
    input  logic       checksum_ok,
    input  logic [7:0] received_checksum,
    input  logic [7:0] computed_checksum,
    input  logic [6:0] body_length,
    output int         mismatches,
    output int         outstanding
);
    import nsf_pkg::*;

    localparam int MAX_PRINTED = 200;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_BODY, SCAN_HIGH, SCAN_LOW} scan_t;

    typedef struct packed {
        kind_t      kind;
        logic       ok;
        logic [7:0] received;
        logic [7:0] computed;
        logic [6:0] length;
    } sentence_t;

    scan_t      scan;
    logic [7:0] xor_sum;
    logic [3:0] high_nibble;
    logic [6:0] body_count;
    logic [7:0] header [HDR_LEN];
    sentence_t  expected_sentences [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
        begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return c[3:0];
        end
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
        begin
            return c[3:0] + 4'd9;
        end
        return 4'd0;
    endfunction

    function automatic kind_t header_kind();
        logic [55:0] h;
        kind_t       k;
        h = {header[0], header[1], header[2], header[3], header[4], header[5], header[6]};
        k = KIND_OTHER;
        if (h[55:40] == STR_GP)
        begin
            case (h[39:16])
                STR_RMC: k = KIND_RMC;
                STR_GGA: k = KIND_GGA;
                STR_GSA: k = KIND_GSA;
                STR_GSV: k = KIND_GSV;
                default: k = KIND_OTHER;
            endcase
        end
        else if (h[55:24] == STR_PMTK)
        begin
            if (h[23:0] == STR_011)
            begin
                k = KIND_PMTK011;
            end
            else if (h[23:0] == STR_010)
            begin
                k = KIND_PMTK010;
            end
        end
        return k;
    endfunction

    task automatic clear_header();
        int i;
        for (i = 0; i < HDR_LEN; i++)
        begin
            header[i] = 8'h00;
        end
    endtask

    task automatic take_byte(input logic [7:0] c);
        sentence_t  s;
        logic [7:0] got_sum;
        case (scan)
            SCAN_IDLE:
            begin
                if (c == CHAR_DOLLAR)
                begin
                    xor_sum    = 8'h00;
                    body_count = 7'd0;
                    clear_header();
                    scan = SCAN_BODY;
                end
            end
            SCAN_BODY:
            begin
                if (body_count + 1 >= MAX_SENTENCE_LEN)
                begin
                    body_count = 7'd0;
                    scan       = SCAN_IDLE;
                end
                else if (c == CHAR_STAR)
                begin
                    scan = SCAN_HIGH;
                end
                else
                begin
                    xor_sum ^= c;
                    if (body_count < HDR_LEN)
                    begin
                        header[body_count[2:0]] = c;
                    end
                    body_count++;
                end
            end
            SCAN_HIGH:
            begin
                high_nibble = digit_value(c);
                scan        = SCAN_LOW;
            end
            default:
            begin
                got_sum    = {high_nibble, digit_value(c)};
                s.kind     = header_kind();
                s.ok       = (got_sum == xor_sum);
                s.received = got_sum;
                s.computed = xor_sum;
                s.length   = body_count;
                expected_sentences.push_back(s);
                body_count = 7'd0;
                scan       = SCAN_IDLE;
            end
        endcase
    endtask

    task automatic check_result();
        sentence_t want;
        if (expected_sentences.size() == 0)
        begin
            report_mismatch($sformatf("result with no sentence pending, kind %0d length %0d",
                                      sentence_kind, body_length));
        end
        else
        begin
            want = expected_sentences.pop_front();
            if (sentence_kind != want.kind)
            begin
                report_mismatch($sformatf("sentence_kind got %0d want %0d",
                                          sentence_kind, want.kind));
            end
            if (checksum_ok != want.ok)
            begin
                report_mismatch($sformatf("checksum_ok got %0d want %0d", checksum_ok, want.ok));
            end
            if (received_checksum != want.received)
            begin
                report_mismatch($sformatf("received_checksum got %02h want %02h",
                                          received_checksum, want.received));
            end
            if (computed_checksum != want.computed)
            begin
                report_mismatch($sformatf("computed_checksum got %02h want %02h",
                                          computed_checksum, want.computed));
            end
            if (body_length != want.length)
            begin
                report_mismatch($sformatf("body_length got %0d want %0d",
                                          body_length, want.length));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan        = SCAN_IDLE;
            xor_sum     = 8'h00;
            high_nibble = 4'h0;
            body_count  = 7'd0;
            clear_header();
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                check_result();
            end
            if (byte_valid && !byte_stall)
            begin
                take_byte(rx_byte);
            end
            outstanding = expected_sentences.size();
        end
    end

endmodule

### dv/tb_nmea_sentence_framer_top.sv
`timescale 1ns / 100ps

module tb_nmea_sentence_framer_top;
    import nsf_pkg::*;

    localparam int IDLE_PCT       = 31;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 1800;
    localparam int SETTLE_CYCLES  = 8;
    localparam int N_HEADERS      = 11;

    typedef enum int {CK_UPPER, CK_LOWER, CK_WRONG, CK_RAW, CK_CUT} ck_mode_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       byte_valid   = 1'b0;
    logic [7:0] rx_byte      = 8'h00;
    logic       result_stall = 1'b0;

    logic       byte_stall;
    logic       result_valid;
    logic [2:0] sentence_kind;
    logic       checksum_ok;
    logic [7:0] received_checksum;
    logic [7:0] computed_checksum;
    logic [6:0] body_length;

    int         mismatches;
    int         outstanding;
    int         sent_bytes    = 0;
    int         stalled_count = 0;
    logic       sender_steady = 1'b0;
    logic [7:0] body_bytes [$];

    string headers [N_HEADERS] = '{"GPRMC", "GPGGA", "GPGSA", "GPGSV", "PMTK011", "PMTK010",
                                   "GPZDA", "PMTK220", "GPRMX", "PMTK01", ""};

    always #2 clk = ~clk;

    nmea_sentence_framer_top dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .byte_valid        (byte_valid),
        .byte_stall        (byte_stall),
        .rx_byte           (rx_byte),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .sentence_kind     (sentence_kind),
        .checksum_ok       (checksum_ok),
        .received_checksum (received_checksum),
        .computed_checksum (computed_checksum),
        .body_length       (body_length)
    );

    nmea_sentence_framer_checker framer_check
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .byte_valid        (byte_valid),
        .byte_stall        (byte_stall),
        .rx_byte           (rx_byte),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .sentence_kind     (sentence_kind),
        .checksum_ok       (checksum_ok),
        .received_checksum (received_checksum),
        .computed_checksum (computed_checksum),
        .body_length       (body_length),
        .mismatches        (mismatches),
        .outstanding       (outstanding)
    );

    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
        begin
            stalled_count <= 0;
        end
        else
        begin
            stalled_count <= stalled_count + 1;
        end
        if (stalled_count >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : receiver
        int cycle;
        cycle = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle >= 600 && cycle < 900)
            begin
                result_stall <= 1'b1;
            end
            else if (cycle >= 1500 && cycle < 1900)
            begin
                result_stall <= 1'b0;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!sender_steady && $urandom_range(99) < IDLE_PCT)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        rx_byte    <= b;
        @(posedge clk);
        while (byte_stall)
        begin
            @(posedge clk);
        end
        sent_bytes++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
        if (n < 10)
        begin
            return "0" + n;
        end
        return (lower ? "a" : "A") + n - 8'd10;
    endfunction

    task automatic load_text(input string s);
        int i;
        body_bytes.delete();
        for (i = 0; i < s.len(); i++)
        begin
            body_bytes.push_back(s[i]);
        end
    endtask

    task automatic send_body(output logic [7:0] sum);
        int i;
        sum = 8'h00;
        send_byte(CHAR_DOLLAR);
        for (i = 0; i < body_bytes.size(); i++)
        begin
            send_byte(body_bytes[i]);
            sum ^= body_bytes[i];
        end
    endtask

    task automatic send_checksum(input ck_mode_t mode, input logic [7:0] sum);
        logic [7:0] v;
        logic [7:0] r;
        v = sum;
        if (mode == CK_WRONG)
        begin
            r = 8'($urandom_range(1, 255));
            v = sum ^ r;
        end
        send_byte(CHAR_STAR);
        if (mode == CK_RAW)
        begin
            r = 8'($urandom_range(255));
            send_byte(r);
            r = 8'($urandom_range(255));
            send_byte(r);
        end
        else
        begin
            send_byte(hex_char(v[7:4], mode == CK_LOWER));
            if (mode != CK_CUT)
            begin
                send_byte(hex_char(v[3:0], mode == CK_LOWER));
            end
        end
    endtask

    task automatic random_sentence(input int index);
        int         i;
        int         len;
        int         pick;
        string      head;
        logic [7:0] b;
        logic [7:0] sum;
        ck_mode_t   mode;
        head = headers[$urandom_range(N_HEADERS - 1)];
        pick = $urandom_range(99);
        if (index == 0)
        begin
            len = MAX_SENTENCE_LEN - 2;
        end
        else if (index == 1)
        begin
            len = MAX_SENTENCE_LEN - 1;
        end
        else if (pick < 70)
        begin
            len = head.len() + $urandom_range(15);
        end
        else if (pick < 85)
        begin
            len = $urandom_range(6);
        end
        else if (pick < 94)
        begin
            len = $urandom_range(40, MAX_SENTENCE_LEN - 2);
        end
        else
        begin
            len = $urandom_range(MAX_SENTENCE_LEN - 1, MAX_SENTENCE_LEN + 4);
        end
        body_bytes.delete();
        for (i = 0; i < len; i++)
        begin
            if (i < head.len())
            begin
                b = head[i];
            end
            else
            begin
                b = 8'($urandom_range(255));
                if (b == CHAR_STAR)
                begin
                    b = CHAR_DOLLAR;
                end
            end
            body_bytes.push_back(b);
        end
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            mode = CK_UPPER;
        end
        else if (pick < 70)
        begin
            mode = CK_LOWER;
        end
        else if (pick < 82)
        begin
            mode = CK_WRONG;
        end
        else if (pick < 94)
        begin
            mode = CK_RAW;
        end
        else
        begin
            mode = CK_CUT;
        end
        send_body(sum);
        send_checksum(mode, sum);
        if ($urandom_range(99) < 30)
        begin
            repeat ($urandom_range(1, 3))
            begin
                b = 8'($urandom_range(255));
                send_byte(b);
            end
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] sum;
        int         n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00);
        send_byte(8'hFF);
        body_bytes.delete();
        send_body(sum);
        send_checksum(CK_UPPER, sum);
        load_text("GPRMC");
        send_body(sum);
        send_checksum(CK_UPPER, sum);
        load_text("PMTK010");
        send_body(sum);
        send_byte(CHAR_STAR);
        send_byte(CHAR_DOLLAR);
        send_byte("g");

        n = 0;
        while (sent_bytes < ITEM_TARGET)
        begin
            sender_steady = (sent_bytes >= 700 && sent_bytes < 1000);
            random_sentence(n);
            n++;
        end
        byte_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
